// ----- src/pdv_pkg.sv -----
// Package for the patch difference variance block.
// Holds register indexes, field widths and reset values shared by the files that import it.
// No dependencies.
`timescale 1ns / 1ps

package pdv_pkg;

  localparam int PIX_W     = 8;
  localparam int COST_W    = 24;
  localparam int PDIM_W    = 7;
  localparam int IDIM_W    = 12;
  localparam int CFG_W     = 12;
  localparam int CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] REG_PATCH_WIDTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PATCH_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_X_OFFSET     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_Y_OFFSET     = 3'd5;

  localparam logic [PDIM_W-1:0] PATCH_WIDTH_RST  = 7'd8;
  localparam logic [PDIM_W-1:0] PATCH_HEIGHT_RST = 7'd8;
  localparam logic [IDIM_W-1:0] IMAGE_WIDTH_RST  = 12'd640;
  localparam logic [IDIM_W-1:0] IMAGE_HEIGHT_RST = 12'd480;

endpackage

// ----- src/pdv_queue.sv -----
// Two-entry queue of finished patch sums between front and back.
// Depends on nothing but its WIDTH parameter.
`timescale 1ns / 1ps

module pdv_queue #(
  parameter int WIDTH = 64
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output logic             empty
);

  logic [WIDTH-1:0] entry_r [2];
  logic             wr_ptr_r;
  logic             rd_ptr_r;
  logic [1:0]       count_r;
  logic [1:0]       count_nxt;

  assign full     = (count_r == 2'd2);
  assign empty    = (count_r == 2'd0);
  assign pop_data = entry_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 2'd1;
    end else if (pop && !push) begin
      count_nxt = count_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      count_r <= count_nxt;
    end
  end

`ifndef SYNTHESIS
  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n) !(push && full))
    else $error("queue written while full");
  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n) !(pop && empty))
    else $error("queue read while empty");
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
      (count_r != 2'd3) && ((wr_ptr_r == rd_ptr_r) == (count_r != 2'd1)))
    else $error("queue count and pointers disagree");
`endif

endmodule

// ----- src/pdv_front.sv -----
// Front end: configuration registers, patch position counters and the
// running count, sum and square sum of pixel differences. Uses pdv_pkg.
`timescale 1ns / 1ps

module pdv_front #(
  parameter int MAX_PATCH_DIM  = 64,
  parameter int IMAGE_DIM_BITS = 12,
  parameter int ENTRY_W        = 64
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [pdv_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [pdv_pkg::CFG_W-1:0]     cfg_wdata,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [pdv_pkg::PIX_W-1:0]     in_patch_pixel,
  input  logic [pdv_pkg::PIX_W-1:0]     in_image_pixel,
  output logic                          q_push,
  output logic [ENTRY_W-1:0]            q_data,
  input  logic                          q_full
);

  import pdv_pkg::*;

  localparam int IMG_BITS = (IMAGE_DIM_BITS < IDIM_W) ? IMAGE_DIM_BITS : IDIM_W;
  localparam int CNT_W    = $clog2(MAX_PATCH_DIM + 1);
  localparam int DIM_W    = (CNT_W > PDIM_W) ? CNT_W : PDIM_W;
  localparam int SUM_W    = ((CNT_W > IMG_BITS) ? CNT_W : IMG_BITS) + 1;
  localparam int NW       = $clog2(MAX_PATCH_DIM * MAX_PATCH_DIM + 1);
  localparam int SW       = NW + PIX_W + 1;
  localparam int QW       = NW + 2 * PIX_W;

  logic [PDIM_W-1:0]   patch_width_r;
  logic [PDIM_W-1:0]   patch_height_r;
  logic [IMG_BITS-1:0] image_width_r;
  logic [IMG_BITS-1:0] image_height_r;
  logic [IMG_BITS-1:0] x_offset_r;
  logic [IMG_BITS-1:0] y_offset_r;

  logic [CNT_W-1:0]    col_r;
  logic [CNT_W-1:0]    row_r;
  logic [NW-1:0]       n_r;
  logic signed [SW-1:0] s_r;
  logic [QW-1:0]       q_r;

  logic [NW-1:0]       n_nxt;
  logic signed [SW-1:0] s_nxt;
  logic [QW-1:0]       q_nxt;

  logic [DIM_W-1:0]    eff_w;
  logic [DIM_W-1:0]    eff_h;
  logic [SUM_W-1:0]    img_col;
  logic [SUM_W-1:0]    img_row;
  logic                pair_in_image;
  logic                last_col;
  logic                last_row;
  logic                accept;
  logic signed [PIX_W:0]     diff;
  logic signed [2*PIX_W+1:0] diff_sq_full;

  function automatic logic [DIM_W-1:0] clamp_dim(input logic [PDIM_W-1:0] v);
    logic [DIM_W-1:0] ext;
    ext = DIM_W'(v);
    if (ext == '0) begin
      return DIM_W'(1);
    end else if (ext > DIM_W'(MAX_PATCH_DIM)) begin
      return DIM_W'(MAX_PATCH_DIM);
    end
    return ext;
  endfunction

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;

  assign eff_w    = clamp_dim(patch_width_r);
  assign eff_h    = clamp_dim(patch_height_r);
  assign last_col = (DIM_W'(col_r) + DIM_W'(1)) >= eff_w;
  assign last_row = (DIM_W'(row_r) + DIM_W'(1)) >= eff_h;

  assign img_col = SUM_W'(col_r) + SUM_W'(x_offset_r);
  assign img_row = SUM_W'(row_r) + SUM_W'(y_offset_r);
  assign pair_in_image = (img_col < SUM_W'(image_width_r)) &&
                         (img_row < SUM_W'(image_height_r));

  assign diff         = $signed({1'b0, in_patch_pixel}) - $signed({1'b0, in_image_pixel});
  assign diff_sq_full = diff * diff;

  always_comb begin
    n_nxt = n_r;
    s_nxt = s_r;
    q_nxt = q_r;
    if (pair_in_image) begin
      n_nxt = n_r + NW'(1);
      s_nxt = s_r + SW'(diff);
      q_nxt = q_r + QW'(diff_sq_full[2*PIX_W-1:0]);
    end
  end

  // The patch closes on the last column of the last row; the sums of that
  // beat, its own pair included, go to the queue.
  assign q_push = accept && last_col && last_row;
  assign q_data = {n_nxt, s_nxt, q_nxt};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      patch_width_r  <= PATCH_WIDTH_RST;
      patch_height_r <= PATCH_HEIGHT_RST;
      image_width_r  <= IMAGE_WIDTH_RST[IMG_BITS-1:0];
      image_height_r <= IMAGE_HEIGHT_RST[IMG_BITS-1:0];
      x_offset_r     <= '0;
      y_offset_r     <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_PATCH_WIDTH:  patch_width_r  <= cfg_wdata[PDIM_W-1:0];
        REG_PATCH_HEIGHT: patch_height_r <= cfg_wdata[PDIM_W-1:0];
        REG_IMAGE_WIDTH:  image_width_r  <= cfg_wdata[IMG_BITS-1:0];
        REG_IMAGE_HEIGHT: image_height_r <= cfg_wdata[IMG_BITS-1:0];
        REG_X_OFFSET:     x_offset_r     <= cfg_wdata[IMG_BITS-1:0];
        REG_Y_OFFSET:     y_offset_r     <= cfg_wdata[IMG_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
      n_r   <= '0;
      s_r   <= '0;
      q_r   <= '0;
    end else if (accept) begin
      if (!last_col) begin
        col_r <= col_r + CNT_W'(1);
        n_r   <= n_nxt;
        s_r   <= s_nxt;
        q_r   <= q_nxt;
      end else if (!last_row) begin
        col_r <= '0;
        row_r <= row_r + CNT_W'(1);
        n_r   <= n_nxt;
        s_r   <= s_nxt;
        q_r   <= q_nxt;
      end else begin
        col_r <= '0;
        row_r <= '0;
        n_r   <= '0;
        s_r   <= '0;
        q_r   <= '0;
      end
    end
  end

endmodule

// ----- src/pdv_back.sv -----
// Back end: turns one patch's count, sum and square sum into the Q.8
// variance with three multipliers and a bit-serial divider. Uses pdv_pkg.
`timescale 1ns / 1ps

module pdv_back #(
  parameter int MAX_PATCH_DIM = 64,
  parameter int ENTRY_W       = 64
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       q_empty,
  input  logic [ENTRY_W-1:0]         q_data,
  output logic                       q_pop,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [pdv_pkg::COST_W-1:0] out_cost_q8,
  output logic                       out_empty_overlap
);

  import pdv_pkg::*;

  localparam int NW     = $clog2(MAX_PATCH_DIM * MAX_PATCH_DIM + 1);
  localparam int SW     = NW + PIX_W + 1;
  localparam int QW     = NW + 2 * PIX_W;
  localparam int MAG_W  = SW - 1;
  localparam int NUM_W  = NW + QW;
  localparam int DEN_W  = 2 * NW;
  localparam int FRAC_W = 8;
  localparam int LO_W   = COST_W;
  localparam int CNT_W  = $clog2(COST_W);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_MUL  = 3'd1;
  localparam logic [2:0] ST_SUB  = 3'd2;
  localparam logic [2:0] ST_PREP = 3'd3;
  localparam logic [2:0] ST_DIV  = 3'd4;
  localparam logic [2:0] ST_FIN  = 3'd5;

  logic [2:0]           state_r;
  logic [NW-1:0]        n_r;
  logic signed [SW-1:0] s_r;
  logic [QW-1:0]        q_r;
  logic [NUM_W-1:0]     prod_r;
  logic [NUM_W-1:0]     s2_r;
  logic [NUM_W-1:0]     num_r;
  logic [DEN_W-1:0]     den_r;
  logic [DEN_W-1:0]     rem_r;
  logic [LO_W-1:0]      lo_r;
  logic [COST_W-1:0]    quot_r;
  logic [CNT_W-1:0]     cnt_r;
  logic                 empty_r;
  logic                 out_valid_r;
  logic [COST_W-1:0]    out_cost_r;
  logic                 out_empty_r;

  logic [MAG_W-1:0]     s_mag;
  logic [SW-1:0]        s_neg;
  logic [DEN_W-1:0]     hi_part;
  logic [DEN_W:0]       trial;
  logic                 trial_ge;
  logic                 out_free;

  assign s_neg    = SW'(-s_r);
  assign s_mag    = s_r[SW-1] ? s_neg[MAG_W-1:0] : s_r[MAG_W-1:0];
  // num * 256 / den: the quotient bits above COST_W come from num >> 16.
  assign hi_part  = num_r[NUM_W-1 -: DEN_W];
  assign trial    = {rem_r, lo_r[LO_W-1]};
  assign trial_ge = trial >= {1'b0, den_r};
  assign out_free = !out_valid_r || !out_stall;

  assign q_pop             = (state_r == ST_IDLE) && !q_empty;
  assign out_valid         = out_valid_r;
  assign out_cost_q8       = out_cost_r;
  assign out_empty_overlap = out_empty_r;

  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        n_r     <= q_data[ENTRY_W-1 -: NW];
        s_r     <= q_data[QW+SW-1 -: SW];
        q_r     <= q_data[QW-1:0];
        empty_r <= (q_data[ENTRY_W-1 -: NW] == '0);
        quot_r  <= '0;
      end
      ST_MUL: begin
        prod_r <= NUM_W'(n_r * q_r);
        s2_r   <= NUM_W'(s_mag * s_mag);
        den_r  <= DEN_W'(n_r * n_r);
      end
      ST_SUB: begin
        num_r <= prod_r - s2_r;
      end
      ST_PREP: begin
        rem_r  <= hi_part;
        lo_r   <= {num_r[LO_W-FRAC_W-1:0], {FRAC_W{1'b0}}};
        cnt_r  <= CNT_W'(COST_W - 1);
        quot_r <= (hi_part >= den_r) ? {COST_W{1'b1}} : '0;
      end
      ST_DIV: begin
        rem_r  <= trial_ge ? DEN_W'(trial - {1'b0, den_r}) : trial[DEN_W-1:0];
        lo_r   <= {lo_r[LO_W-2:0], 1'b0};
        quot_r <= {quot_r[COST_W-2:0], trial_ge};
        cnt_r  <= cnt_r - CNT_W'(1);
      end
      default: ;
    endcase
    if (state_r == ST_FIN && out_free) begin
      out_cost_r  <= quot_r;
      out_empty_r <= empty_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      if (state_r == ST_FIN && out_free) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (!q_empty) begin
            state_r <= (q_data[ENTRY_W-1 -: NW] == '0) ? ST_FIN : ST_MUL;
          end
        end
        ST_MUL:  state_r <= ST_SUB;
        ST_SUB:  state_r <= ST_PREP;
        ST_PREP: state_r <= (hi_part >= den_r) ? ST_FIN : ST_DIV;
        ST_DIV: begin
          if (cnt_r == '0) begin
            state_r <= ST_FIN;
          end
        end
        ST_FIN: begin
          if (out_free) begin
            state_r <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_pop_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
      q_pop |-> (state_r == ST_IDLE))
    else $error("queue popped outside idle");
  a_div_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
      (state_r == ST_DIV) |-> (rem_r < den_r))
    else $error("divider remainder not below divisor");
  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
      (out_valid_r && out_empty_r) |-> (out_cost_r == '0))
    else $error("empty overlap result with nonzero cost");
`endif

endmodule

// ----- src/patch_difference_variance_top.sv -----
// Top level of the patch difference variance block.
// Instantiates pdv_front, pdv_queue and pdv_back; uses pdv_pkg.
`timescale 1ns / 1ps

// Usage:
// The input channel carries one beat per patch pixel in row-major order,
// each with the image pixel at the same placed position. The front end
// takes one beat per cycle while in_stall is low and keeps count, sum and
// square sum of the differences for pairs inside the image. When the last
// pixel of a patch is taken, those sums go into a two-entry queue and the
// counters clear. The back end turns each queued patch into one output
// beat: the Q.8 variance of the differences, or cost 0 with empty_overlap
// set when no pair fell inside. A patch passes through the back end as the
// pop, a multiply step, a subtract step, one divider setup step, 24 steps
// of the restoring divider and the output step; an empty overlap goes from
// the pop straight to the output step. in_stall rises while the queue is
// full, so patches that come faster than the back end finishes them back
// up the input.
// The output register holds its beat while out_stall is high, and the back
// end can finish the next patch behind it meanwhile.
// Reset (rst_n low at a clock edge) restores the configuration registers
// and clears counters, sums, the queue and any pending output beat.
// Configuration writes take effect at the next edge.

module patch_difference_variance_top #(
  parameter int MAX_PATCH_DIM  = 64,
  parameter int IMAGE_DIM_BITS = 12
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [pdv_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [pdv_pkg::CFG_W-1:0]     cfg_wdata,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [pdv_pkg::PIX_W-1:0]     in_patch_pixel,
  input  logic [pdv_pkg::PIX_W-1:0]     in_image_pixel,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [pdv_pkg::COST_W-1:0]    out_cost_q8,
  output logic                          out_empty_overlap
);

  import pdv_pkg::*;

  localparam int NW      = $clog2(MAX_PATCH_DIM * MAX_PATCH_DIM + 1);
  localparam int ENTRY_W = NW + (NW + PIX_W + 1) + (NW + 2 * PIX_W);

  logic               q_push;
  logic [ENTRY_W-1:0] q_push_data;
  logic               q_full;
  logic               q_pop;
  logic [ENTRY_W-1:0] q_pop_data;
  logic               q_empty;

  pdv_front #(
    .MAX_PATCH_DIM (MAX_PATCH_DIM),
    .IMAGE_DIM_BITS(IMAGE_DIM_BITS),
    .ENTRY_W       (ENTRY_W)
  ) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_patch_pixel(in_patch_pixel),
    .in_image_pixel(in_image_pixel),
    .q_push        (q_push),
    .q_data        (q_push_data),
    .q_full        (q_full)
  );

  pdv_queue #(
    .WIDTH(ENTRY_W)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_data(q_push_data),
    .full     (q_full),
    .pop      (q_pop),
    .pop_data (q_pop_data),
    .empty    (q_empty)
  );

  pdv_back #(
    .MAX_PATCH_DIM(MAX_PATCH_DIM),
    .ENTRY_W      (ENTRY_W)
  ) u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_empty          (q_empty),
    .q_data           (q_pop_data),
    .q_pop            (q_pop),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_cost_q8      (out_cost_q8),
    .out_empty_overlap(out_empty_overlap)
  );

endmodule

// ----- tb/pdv_checker.sv -----
// Checker for the patch difference variance block: watches the configuration
// port and both channels, predicts every cost beat and compares it with the DUT.
// Depends on pdv_pkg.
`timescale 1ns / 1ps

module pdv_checker #(
  parameter int MAX_PATCH_DIM = 64
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [pdv_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [pdv_pkg::CFG_W-1:0]     cfg_wdata,
  input  logic                          in_valid,
  input  logic                          in_stall,
  input  logic [pdv_pkg::PIX_W-1:0]     in_patch_pixel,
  input  logic [pdv_pkg::PIX_W-1:0]     in_image_pixel,
  input  logic                          out_valid,
  input  logic                          out_stall,
  input  logic [pdv_pkg::COST_W-1:0]    out_cost_q8,
  input  logic                          out_empty_overlap,
  output int                            fail_count,
  output int                            pending,
  output int                            checked_count
);
  import pdv_pkg::*;

  localparam longint COST_MAX = (longint'(1) << COST_W) - 1;

  typedef struct packed {
    logic [COST_W-1:0] cost_q8;
    logic              empty_overlap;
  } cost_beat_t;

  logic [PDIM_W-1:0] patch_w_r, patch_h_r;
  logic [IDIM_W-1:0] img_w_r, img_h_r, x_off_r, y_off_r;
  int                row_pos, col_pos, pair_n;
  longint            diff_sum, square_sum;
  cost_beat_t        expected_costs[$];
  cost_beat_t        exp_beat;
  int                w_eff, h_eff, diff;

  initial begin
    fail_count    = 0;
    pending       = 0;
    checked_count = 0;
  end

  function automatic int clamp_dim(input logic [PDIM_W-1:0] v);
    if (v == 0) return 1;
    if (v > MAX_PATCH_DIM) return MAX_PATCH_DIM;
    return v;
  endfunction

  function automatic cost_beat_t variance_beat(input int n, input longint s, input longint q);
    cost_beat_t b;
    longint     num, cost;
    if (n == 0) begin
      b.cost_q8       = '0;
      b.empty_overlap = 1'b1;
      return b;
    end
    num  = longint'(n) * q - s * s;
    cost = (num * 256) / (longint'(n) * n);
    if (cost > COST_MAX) cost = COST_MAX;
    b.cost_q8       = cost[COST_W-1:0];
    b.empty_overlap = 1'b0;
    return b;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("%0t ns mismatch: %s", $time, msg);
    fail_count++;
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      patch_w_r  <= PATCH_WIDTH_RST;
      patch_h_r  <= PATCH_HEIGHT_RST;
      img_w_r    <= IMAGE_WIDTH_RST;
      img_h_r    <= IMAGE_HEIGHT_RST;
      x_off_r    <= '0;
      y_off_r    <= '0;
      row_pos    = 0;
      col_pos    = 0;
      pair_n     = 0;
      diff_sum   = 0;
      square_sum = 0;
      expected_costs.delete();
    end else begin
      // Results are taken before new beats, so an expectation pushed at this
      // edge can never be matched against a result that left earlier.
      if (out_valid && !out_stall) begin
        if (expected_costs.size() == 0) begin
          report_mismatch($sformatf("unexpected cost beat cost_q8=%0d empty_overlap=%0b",
                                    out_cost_q8, out_empty_overlap));
        end else begin
          exp_beat = expected_costs.pop_front();
          if (out_cost_q8 !== exp_beat.cost_q8 ||
              out_empty_overlap !== exp_beat.empty_overlap) begin
            report_mismatch($sformatf(
              "cost beat %0d: cost_q8 %0d expected %0d, empty_overlap %0b expected %0b",
              checked_count, out_cost_q8, exp_beat.cost_q8,
              out_empty_overlap, exp_beat.empty_overlap));
          end
          checked_count <= checked_count + 1;
        end
      end

      if (in_valid && !in_stall) begin
        w_eff = clamp_dim(patch_w_r);
        h_eff = clamp_dim(patch_h_r);
        if (row_pos + int'(y_off_r) < int'(img_h_r) &&
            col_pos + int'(x_off_r) < int'(img_w_r)) begin
          diff       = int'(in_patch_pixel) - int'(in_image_pixel);
          pair_n     = pair_n + 1;
          diff_sum   = diff_sum + diff;
          square_sum = square_sum + diff * diff;
        end
        if (col_pos + 1 < w_eff) begin
          col_pos = col_pos + 1;
        end else if (row_pos + 1 < h_eff) begin
          col_pos = 0;
          row_pos = row_pos + 1;
        end else begin
          expected_costs.push_back(variance_beat(pair_n, diff_sum, square_sum));
          row_pos    = 0;
          col_pos    = 0;
          pair_n     = 0;
          diff_sum   = 0;
          square_sum = 0;
        end
      end

      if (cfg_we) begin
        case (cfg_index)
          REG_PATCH_WIDTH:  patch_w_r <= cfg_wdata[PDIM_W-1:0];
          REG_PATCH_HEIGHT: patch_h_r <= cfg_wdata[PDIM_W-1:0];
          REG_IMAGE_WIDTH:  img_w_r   <= cfg_wdata[IDIM_W-1:0];
          REG_IMAGE_HEIGHT: img_h_r   <= cfg_wdata[IDIM_W-1:0];
          REG_X_OFFSET:     x_off_r   <= cfg_wdata[IDIM_W-1:0];
          REG_Y_OFFSET:     y_off_r   <= cfg_wdata[IDIM_W-1:0];
          default: ;
        endcase
      end
    end
    pending <= expected_costs.size();
  end

endmodule

// ----- tb/testbench.sv -----
// Top of the patch difference variance testbench: clock, reset, configuration
// phases, pixel-pair stimulus and output back-pressure, plus the final verdict.
// Depends on pdv_pkg, pdv_checker and patch_difference_variance_top.
`timescale 1ns / 1ps

module testbench;
  import pdv_pkg::*;

  localparam int MAX_DIM      = 64;
  localparam int LATENCY_WAIT = 40;
  localparam int LONG_HOLD    = 400;
  localparam int RANDOM_ITEMS = 1100;
  localparam int CYCLE_LIMIT  = 600000;

  typedef enum int {
    FILL_RANDOM,
    FILL_EQUAL,
    FILL_EXTREME,
    FILL_OFFSET
  } fill_mode_t;

  logic                 clk               = 1'b0;
  logic                 rst_n             = 1'b0;
  logic                 cfg_we            = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index         = '0;
  logic [CFG_W-1:0]     cfg_wdata         = '0;
  logic                 in_valid          = 1'b0;
  logic                 in_stall;
  logic [PIX_W-1:0]     in_patch_pixel    = '0;
  logic [PIX_W-1:0]     in_image_pixel    = '0;
  logic                 out_valid;
  logic                 out_stall         = 1'b0;
  logic [COST_W-1:0]    out_cost_q8;
  logic                 out_empty_overlap;

  int fail_count, pending, checked_count;
  int cycle_count = 0;
  int items_sent  = 0;
  int phase_count = 0;
  int cur_w       = 8;
  int cur_h       = 8;
  bit in_quiet    = 1'b0;
  bit out_quiet   = 1'b0;
  bit hold_req    = 1'b0;

  patch_difference_variance_top #(
    .MAX_PATCH_DIM (MAX_DIM),
    .IMAGE_DIM_BITS(IDIM_W)
  ) u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_patch_pixel   (in_patch_pixel),
    .in_image_pixel   (in_image_pixel),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_cost_q8      (out_cost_q8),
    .out_empty_overlap(out_empty_overlap)
  );

  pdv_checker #(
    .MAX_PATCH_DIM(MAX_DIM)
  ) u_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_patch_pixel   (in_patch_pixel),
    .in_image_pixel   (in_image_pixel),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_cost_q8      (out_cost_q8),
    .out_empty_overlap(out_empty_overlap),
    .fail_count       (fail_count),
    .pending          (pending),
    .checked_count    (checked_count)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d cost beats outstanding", cycle_count, pending);
      $display("Simulation FAILED");
      $finish;
    end
  end

  function automatic int effective_dim(input logic [PDIM_W-1:0] v);
    if (v == 0) return 1;
    if (v > MAX_DIM) return MAX_DIM;
    return v;
  endfunction

  function automatic logic [PDIM_W-1:0] pick_dim(input bit keep_small);
    int r;
    r = $urandom_range(0, 19);
    if (keep_small) return PDIM_W'($urandom_range(1, 4));
    if (r == 0) return '0;
    if (r == 1) return PDIM_W'($urandom_range(MAX_DIM + 1, 127));
    if (r <= 3) return PDIM_W'($urandom_range(9, MAX_DIM));
    return PDIM_W'($urandom_range(1, 6));
  endfunction

  function automatic logic [IDIM_W-1:0] pick_image_dim();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return '0;
    if (r == 1) return '1;
    if (r <= 5) return IDIM_W'($urandom_range(1, 16));
    return IDIM_W'($urandom_range(1, 4095));
  endfunction

  function automatic logic [IDIM_W-1:0] pick_offset(input logic [IDIM_W-1:0] img_dim);
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return '1;
    if (r == 1) begin
      return (img_dim > 8) ? IDIM_W'(img_dim - $urandom_range(1, 8))
                           : IDIM_W'($urandom_range(0, 8));
    end
    if (r <= 6) return IDIM_W'($urandom_range(0, 20));
    return IDIM_W'($urandom_range(0, 4095));
  endfunction

  // Writes every register index once, unused ones with random data. The
  // bits above a patch dimension carry random junk that must be dropped.
  task automatic configure(input logic [PDIM_W-1:0] pw, ph,
                           input logic [IDIM_W-1:0] iw, ih, xo, yo);
    logic [CFG_W-1:0] vals [2**CFG_IDX_W];
    for (int i = 0; i < 2**CFG_IDX_W; i++) vals[i] = CFG_W'($urandom);
    vals[REG_PATCH_WIDTH]  = CFG_W'(pw) | (CFG_W'($urandom_range(0, 31)) << PDIM_W);
    vals[REG_PATCH_HEIGHT] = CFG_W'(ph) | (CFG_W'($urandom_range(0, 31)) << PDIM_W);
    vals[REG_IMAGE_WIDTH]  = iw;
    vals[REG_IMAGE_HEIGHT] = ih;
    vals[REG_X_OFFSET]     = xo;
    vals[REG_Y_OFFSET]     = yo;
    for (int i = 0; i < 2**CFG_IDX_W; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= CFG_IDX_W'(i);
      cfg_wdata <= vals[i];
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    cur_w  = effective_dim(pw);
    cur_h  = effective_dim(ph);
    phase_count++;
  endtask

  // Offers one pixel pair after a random gap and returns at the edge that
  // takes the beat. Valid stays high so a following beat can go back to back.
  task automatic send_pair(input logic [PIX_W-1:0] pp, ip);
    int gap;
    gap = in_quiet ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_patch_pixel <= pp;
    in_image_pixel <= ip;
    do @(posedge clk); while (in_stall);
    items_sent++;
  endtask

  task automatic send_patch(input fill_mode_t mode);
    logic [PIX_W-1:0] pp, ip, shift;
    shift = PIX_W'($urandom);
    for (int i = 0; i < cur_w * cur_h; i++) begin
      ip = PIX_W'($urandom);
      case (mode)
        FILL_EQUAL:   pp = ip;
        FILL_EXTREME: begin
          pp = $urandom_range(0, 1) ? '1 : '0;
          ip = ~pp;
        end
        FILL_OFFSET:  pp = ip + shift;
        default:      pp = PIX_W'($urandom);
      endcase
      send_pair(pp, ip);
    end
  endtask

  // Drops valid, waits for every predicted cost beat, then lets the back
  // end drain before the next register write.
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (LATENCY_WAIT) @(posedge clk);
  endtask

  initial begin : receiver
    int hold;
    wait (rst_n);
    @(posedge clk);
    forever begin
      if (hold_req) begin
        hold     = LONG_HOLD;
        hold_req = 1'b0;
      end else begin
        hold = out_quiet ? 0 : $urandom_range(0, 6);
      end
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!(out_valid && !out_stall));
    end
  end

  initial begin : stimulus
    int               directed_items;
    logic [PDIM_W-1:0] pw, ph;
    logic [IDIM_W-1:0] iw, ih, xo, yo;
    int               patches;

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Single-pixel patches: a lone pair always has zero variance.
    configure(1, 1, 640, 480, 0, 0);
    send_pair(8'd0, 8'd0);
    send_pair(8'd255, 8'd0);
    send_pair(8'd0, 8'd255);
    send_pair(8'd255, 8'd255);
    send_pair(8'd170, 8'd85);
    wait_idle();
    // Differences of +255 and -255 give the largest possible cost.
    configure(2, 1, 640, 480, 0, 0);
    send_pair(8'd255, 8'd0);
    send_pair(8'd0, 8'd255);
    wait_idle();
    // Zero patch sizes act as one; the offset puts the pixel outside.
    configure(0, 0, 640, 480, 4095, 0);
    send_pair(8'd77, 8'd200);
    wait_idle();
    // An image of zero width has no pixel inside.
    configure(2, 2, 0, 480, 0, 0);
    repeat (4) send_pair(PIX_W'($urandom), PIX_W'($urandom));
    wait_idle();
    // Partial overlap: only the first two pairs of the top row are inside.
    configure(3, 2, 3, 1, 1, 0);
    send_pair(8'd200, 8'd10);
    send_pair(8'd10, 8'd200);
    repeat (4) send_pair(PIX_W'($urandom), PIX_W'($urandom));
    wait_idle();
    // Offsets at the top of the range, one just inside and one just outside.
    configure(1, 1, 4095, 4095, 4094, 4094);
    send_pair(8'd1, 8'd254);
    wait_idle();
    configure(1, 1, 4095, 4095, 4095, 4095);
    send_pair(8'd254, 8'd1);
    wait_idle();
    // The second row falls below the image.
    configure(1, 2, 640, 2, 0, 1);
    send_pair(8'd90, 8'd30);
    send_pair(8'd30, 8'd90);
    wait_idle();

    // Output held off for a long stretch while one-pixel patches keep coming,
    // so the result queue fills and the input stalls.
    configure(1, 1, 640, 480, 0, 0);
    in_quiet = 1'b1;
    hold_req = 1'b1;
    repeat (30) send_pair(PIX_W'($urandom), PIX_W'($urandom));
    in_quiet = 1'b0;
    wait_idle();

    directed_items = items_sent;
    while (items_sent - directed_items < RANDOM_ITEMS) begin
      pw = pick_dim(1'b0);
      ph = pick_dim(effective_dim(pw) > 8);
      iw = pick_image_dim();
      ih = pick_image_dim();
      xo = pick_offset(iw);
      yo = pick_offset(ih);
      configure(pw, ph, iw, ih, xo, yo);
      in_quiet  = ($urandom_range(0, 3) == 0);
      out_quiet = ($urandom_range(0, 3) == 0);
      patches   = $urandom_range(1, 4);
      repeat (patches) send_patch(fill_mode_t'($urandom_range(0, 3)));
      wait_idle();
    end

    // One full-width patch of extreme pixels runs the column counter to its
    // limit on every row.
    configure(PDIM_W'(MAX_DIM), 4, 640, 480, 0, 0);
    in_quiet  = 1'b1;
    out_quiet = 1'b1;
    send_patch(FILL_EXTREME);
    wait_idle();

    $display("Run covered %0d pixel beats over %0d register settings; %0d cost beats checked.",
             items_sent, phase_count, checked_count);
    $display("It included clipped and empty overlaps, clamped sizes, a long output hold-off "
             , "and one full-width patch.");
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ----- patch_difference_variance_top.f -----
src/pdv_pkg.sv
src/pdv_queue.sv
src/pdv_front.sv
src/pdv_back.sv
src/patch_difference_variance_top.sv
tb/pdv_checker.sv
tb/testbench.sv
